[rtl/core/cra_pkg.sv]
// Shared types, constants and helper functions of the channel range autocalibrator.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package cra_pkg;

	localparam int CHANNELS = 16;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DATA_W = 32;
	localparam int SH_CNT_W = $clog2(DATA_W) + 1;
	localparam int TBITS_W = 5;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [7:0] byte_t;
	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;
	typedef logic [CH_W-1:0] ch_idx_t;
	typedef logic [TBITS_W-1:0] tbits_t;
	typedef logic [SH_CNT_W-1:0] sh_cnt_t;

	localparam op_t OP_RESTART = 2'd0;
	localparam op_t OP_SETUP = 2'd1;
	localparam op_t OP_SAMPLE = 2'd2;
	localparam op_t OP_CALIBRATE = 2'd3;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_INVERTED = 2'd2;
	localparam status_t ST_DISABLED = 2'd3;

	localparam data_t ALL_ONES = {DATA_W{1'b1}};
	localparam data_t ALL_ZEROS = {DATA_W{1'b0}};
	localparam sh_cnt_t SHIFT_LIMIT = sh_cnt_t'(DATA_W);
	localparam tbits_t TBITS_RESET = tbits_t'(16);

	// Write side of the per-channel store.
	typedef struct packed {
		logic    restart;
		logic    setup;
		logic    sample;
		logic    calib_wb;
		ch_idx_t ch;
		data_t   sample_value;
		logic    last_sample;
		byte_t   source;
		byte_t   shift;
		data_t   offset;
	} store_wr_t;

	// Read side of the per-channel store.
	typedef struct packed {
		data_t minimum;
		data_t maximum;
		logic  enabled;
		byte_t source;
		data_t offset;
		byte_t shift;
	} store_rd_t;

	typedef struct packed {
		logic  start;
		data_t range;
		data_t minimum;
		data_t margin;
		data_t target;
	} unit_req_t;

	typedef struct packed {
		logic  done;
		byte_t shift;
		data_t offset;
	} unit_rsp_t;

	function automatic data_t full_of(input tbits_t tb);
		return (data_t'(1) << tb) - data_t'(1);
	endfunction

	function automatic data_t margin_of(input tbits_t tb);
		return full_of(tb) >> 2;
	endfunction

	function automatic data_t target_of(input tbits_t tb);
		return full_of(tb) - (margin_of(tb) << 1);
	endfunction

endpackage

[rtl/core/cra_if.sv]
// Valid/ready channel interfaces of the channel range autocalibrator.
// Depends on cra_pkg for the payload types.
interface cra_cmd_if;
	logic           valid;
	logic           ready;
	cra_pkg::op_t   operation;
	cra_pkg::byte_t channel;
	cra_pkg::data_t sample_value;
	logic           last_sample;
	cra_pkg::byte_t setup_source;
	cra_pkg::byte_t setup_shift;
	cra_pkg::data_t setup_offset;

	modport source (output valid, operation, channel, sample_value, last_sample,
		setup_source, setup_shift, setup_offset, input ready);
	modport sink (input valid, operation, channel, sample_value, last_sample,
		setup_source, setup_shift, setup_offset, output ready);
endinterface

interface cra_result_if;
	logic             valid;
	logic             ready;
	cra_pkg::byte_t   report_channel;
	cra_pkg::status_t status;
	cra_pkg::byte_t   acq_source;
	cra_pkg::data_t   offset;
	cra_pkg::byte_t   shift;
	cra_pkg::data_t   observed_min;
	cra_pkg::data_t   observed_max;
	cra_pkg::data_t   observed_range;

	modport source (output valid, report_channel, status, acq_source, offset, shift,
		observed_min, observed_max, observed_range, input ready);
	modport sink (input valid, report_channel, status, acq_source, offset, shift,
		observed_min, observed_max, observed_range, output ready);
endinterface

interface cra_cfg_if;
	logic            valid;
	logic            ready;
	cra_pkg::tbits_t target_bits;

	modport source (output valid, target_bits, input ready);
	modport sink (input valid, target_bits, output ready);
endinterface

[rtl/core/cra_store.sv]
// Per-channel state of the autocalibrator: range, enable, source, offset, shift.
// Depends on cra_pkg for the store request and read structs.
module cra_store (
	input  logic               clk,
	input  logic               arst_n,
	input  cra_pkg::store_wr_t wr,
	input  cra_pkg::ch_idx_t   rd_ch,
	output cra_pkg::store_rd_t rd
);

	cra_pkg::data_t             min_q [cra_pkg::CHANNELS];
	cra_pkg::data_t             max_q [cra_pkg::CHANNELS];
	cra_pkg::data_t             off_q [cra_pkg::CHANNELS];
	cra_pkg::byte_t             src_q [cra_pkg::CHANNELS];
	cra_pkg::byte_t             sh_q  [cra_pkg::CHANNELS];
	logic [cra_pkg::CHANNELS-1:0] en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			for (int i = 0; i < cra_pkg::CHANNELS; i++) begin
				min_q[i] <= cra_pkg::ALL_ONES;
				max_q[i] <= cra_pkg::ALL_ZEROS;
				off_q[i] <= cra_pkg::ALL_ZEROS;
				src_q[i] <= '0;
				sh_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < cra_pkg::CHANNELS; i++) begin
				if (wr.restart) begin
					min_q[i] <= cra_pkg::ALL_ONES;
					max_q[i] <= cra_pkg::ALL_ZEROS;
				end else if (wr.ch == cra_pkg::ch_idx_t'(i)) begin
					if (wr.setup) begin
						en_q[i]  <= 1'b0;
						src_q[i] <= wr.source;
						sh_q[i]  <= wr.shift;
						off_q[i] <= wr.offset;
						min_q[i] <= cra_pkg::ALL_ONES;
						max_q[i] <= cra_pkg::ALL_ZEROS;
					end
					if (wr.sample) begin
						if (wr.sample_value < min_q[i])
							min_q[i] <= wr.sample_value;
						if (wr.sample_value > max_q[i])
							max_q[i] <= wr.sample_value;
						if (wr.last_sample)
							en_q[i] <= 1'b1;
					end
					if (wr.calib_wb) begin
						sh_q[i]  <= wr.shift;
						off_q[i] <= wr.offset;
					end
				end
			end
		end
	end

	always_comb begin
		rd.minimum = min_q[rd_ch];
		rd.maximum = max_q[rd_ch];
		rd.enabled = en_q[rd_ch];
		rd.source  = src_q[rd_ch];
		rd.offset  = off_q[rd_ch];
		rd.shift   = sh_q[rd_ch];
	end

endmodule

[rtl/core/cra_shift_unit.sv]
// Iterative shift search: one compare and one-bit right shift per cycle.
// Also forms the floored offset when a search starts. Depends on cra_pkg.
module cra_shift_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  cra_pkg::unit_req_t req,
	output cra_pkg::unit_rsp_t rsp
);

	logic             busy_q;
	cra_pkg::data_t   rem_q;
	cra_pkg::data_t   target_q;
	cra_pkg::data_t   off_q;
	cra_pkg::sh_cnt_t cnt_q;
	logic             step;

	// Keep shifting while the range still exceeds the target and fewer than
	// a full word of shifts have been taken.
	assign step = (cnt_q != cra_pkg::SHIFT_LIMIT) && (rem_q > target_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && !step) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q    <= req.range;
			target_q <= req.target;
			cnt_q    <= '0;
			off_q    <= (req.minimum > req.margin) ? (req.minimum - req.margin)
				: cra_pkg::ALL_ZEROS;
		end else if (busy_q && step) begin
			rem_q <= rem_q >> 1;
			cnt_q <= cnt_q + cra_pkg::sh_cnt_t'(1);
		end
	end

	always_comb begin
		rsp.done   = busy_q && !step;
		rsp.shift  = cra_pkg::byte_t'(cnt_q);
		rsp.offset = off_q;
	end

endmodule

[rtl/core/channel_range_autocalibrator.sv]
// Channel range autocalibrator: restart, setup and sample requests complete in the idle state.
// Calibrate on an enabled channel: the shift search makes one compare per cycle, then the S_EMIT
// state writes the shift and offset back to the store and registers the result; a channel that
// is not enabled goes from idle straight to S_EMIT, which registers the result alone.
// No request is accepted until then, and S_EMIT waits while the result register is still full.
// Asynchronous active-low reset clears all channel state and sets target_bits to 16.
// Depends on cra_pkg, cra_if, cra_store and cra_shift_unit.
module channel_range_autocalibrator (
	input  logic clk,
	input  logic arst_n,
	cra_cmd_if.sink      cmd,
	cra_result_if.source result,
	cra_cfg_if.sink      cfg
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CALC = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic [1:0]         state_d;
	cra_pkg::ch_idx_t   ch_q;
	cra_pkg::tbits_t    tbits_q;
	cra_pkg::ch_idx_t   rd_ch;
	cra_pkg::store_wr_t wr;
	cra_pkg::store_rd_t rd;
	cra_pkg::unit_req_t ureq;
	cra_pkg::unit_rsp_t ursp;
	cra_pkg::status_t   status_d;
	logic               accept;
	logic               ch_ok;
	logic               go;
	logic               out_free;
	logic               emit_go;

	logic             out_valid_q;
	cra_pkg::byte_t   rc_q;
	cra_pkg::status_t st_q;
	cra_pkg::byte_t   src_q;
	cra_pkg::data_t   off_q;
	cra_pkg::byte_t   sh_q;
	cra_pkg::data_t   mn_q;
	cra_pkg::data_t   mx_q;
	cra_pkg::data_t   rng_q;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign ch_ok     = int'(cmd.channel) < cra_pkg::CHANNELS;
	assign go        = accept && ch_ok;
	assign out_free  = !out_valid_q || result.ready;
	assign emit_go   = (state_q == S_EMIT) && out_free;
	assign rd_ch     = (state_q == S_IDLE) ? cmd.channel[cra_pkg::CH_W-1:0] : ch_q;

	cra_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_ch  (rd_ch),
		.rd     (rd)
	);

	cra_shift_unit u_shift (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.rsp    (ursp)
	);

	always_comb begin
		wr.restart      = go && (cmd.operation == cra_pkg::OP_RESTART);
		wr.setup        = go && (cmd.operation == cra_pkg::OP_SETUP);
		wr.sample       = go && (cmd.operation == cra_pkg::OP_SAMPLE);
		wr.calib_wb     = emit_go && rd.enabled;
		wr.ch           = rd_ch;
		wr.sample_value = cmd.sample_value;
		wr.last_sample  = cmd.last_sample;
		wr.source       = cmd.setup_source;
		wr.shift        = wr.calib_wb ? ursp.shift : cmd.setup_shift;
		wr.offset       = wr.calib_wb ? ursp.offset : cmd.setup_offset;
	end

	always_comb begin
		ureq.start   = go && (cmd.operation == cra_pkg::OP_CALIBRATE) && rd.enabled;
		ureq.range   = rd.maximum - rd.minimum;
		ureq.minimum = rd.minimum;
		ureq.margin  = cra_pkg::margin_of(tbits_q);
		ureq.target  = cra_pkg::target_of(tbits_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (go && (cmd.operation == cra_pkg::OP_CALIBRATE))
					state_d = rd.enabled ? S_CALC : S_EMIT;
			end
			S_CALC: begin
				if (ursp.done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		if (!rd.enabled)
			status_d = cra_pkg::ST_DISABLED;
		else if (rd.minimum > rd.maximum)
			status_d = (rd.minimum == cra_pkg::ALL_ONES && rd.maximum == cra_pkg::ALL_ZEROS)
				? cra_pkg::ST_EMPTY : cra_pkg::ST_INVERTED;
		else
			status_d = cra_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tbits_q     <= cra_pkg::TBITS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready)
				tbits_q <= cfg.target_bits;
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go)
			ch_q <= cmd.channel[cra_pkg::CH_W-1:0];
		if (emit_go) begin
			rc_q  <= cra_pkg::byte_t'(ch_q);
			st_q  <= status_d;
			src_q <= rd.source;
			off_q <= rd.enabled ? ursp.offset : rd.offset;
			sh_q  <= rd.enabled ? ursp.shift : rd.shift;
			mn_q  <= rd.minimum;
			mx_q  <= rd.maximum;
			rng_q <= rd.maximum - rd.minimum;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.report_channel = rc_q;
	assign result.status         = st_q;
	assign result.acq_source     = src_q;
	assign result.offset         = off_q;
	assign result.shift          = sh_q;
	assign result.observed_min   = mn_q;
	assign result.observed_max   = mx_q;
	assign result.observed_range = rng_q;

endmodule
